// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, quiet while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen on a rising edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/dcq_pkg.sv -----
`timescale 1ns / 1ps

package dcq_pkg;

  // item field widths
  localparam int unsigned CH_FW    = 4;
  localparam int unsigned TAP_FW   = 3;
  localparam int unsigned VAL_FW   = 16;
  localparam int unsigned TIDX_FW  = 16;
  localparam int unsigned STEP_W   = 17;
  localparam int unsigned Q15_SHIFT = 15;

  // register widths
  localparam int unsigned CHREG_W  = 5;
  localparam int unsigned TAPREG_W = 4;
  localparam int unsigned DILREG_W = 7;
  localparam int unsigned FRREG_W  = 16;

  typedef enum logic [1:0] {
    REG_CHANNELS = 2'd0,
    REG_TAPS     = 2'd1,
    REG_DILATION = 2'd2,
    REG_FRAME    = 2'd3
  } cfg_reg_e;

  // one MAC request from the sequencer
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

// ----- rtl/dilated_conv1d_q15_unit.sv -----
`timescale 1ns / 1ps
// Multichannel dilated causal 1-D convolution, Q15 in and out.
// Input stream: in_tuser = 0 writes one weight (out_channel, in_channel, tap),
// in_tuser = 1 delivers one sample; samples come time-major, channels in order.
// Weights and sample items with no results are taken without holding in_tready low.
// The sample of the last channel of a step starts the sums: for each output
// channel one shared 16x16 MAC reads the weight and history RAMs for every
// input channel and tap, and the sum then passes through the MAC pipeline.
// in_tready is low while sums are running. During warm-up steps no sums run.
// Results leave one per output channel through a single output register;
// the next channel's sum runs while a result waits, and a stalled receiver
// only holds the sequencer once a second result is ready.
// Config port: APB, registers channels, taps, dilation, frame_samples at
// 0x0/0x4/0x8/0xC. A write restarts the frame. A dilation write holds
// in_tready low while the tap spacing is reduced modulo the ring.
// Reset clears control state and loads the register defaults;
// the weight and history RAMs are not cleared and must be written before use.
module dilated_conv1d_q15_unit import dcq_pkg::*; #(
  parameter int unsigned MAX_CHANNELS  = 16,
  parameter int unsigned MAX_TAPS      = 8,
  parameter int unsigned MAX_DILATION  = 64,
  parameter int unsigned HISTORY_DEPTH = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // out_channel[3:0], in_channel[7:4], tap[10:8], value[26:11]
  input  logic        in_tuser,   // func
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_channel_res[3:0], time_index[19:4], value_res[35:20]
  output logic        out_tlast,  // last
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CN_W   = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned TN_W   = $clog2(MAX_TAPS + 1);
  localparam int unsigned HP_W   = $clog2(HISTORY_DEPTH);
  localparam int unsigned WDEPTH = MAX_CHANNELS * MAX_CHANNELS * MAX_TAPS;
  localparam int unsigned HDEPTH = HISTORY_DEPTH * MAX_CHANNELS;
  localparam int unsigned WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int unsigned HA_W   = $clog2(HDEPTH);

  // config registers, stored raw and clamped on use
  logic [CHREG_W-1:0]  ch_r;
  logic [TAPREG_W-1:0] tap_r;
  logic [DILREG_W-1:0] dil_r;
  logic [FRREG_W-1:0]  fr_r;
  logic [DILREG_W-1:0] dm_r;      // clamped dilation reduced mod HISTORY_DEPTH
  logic                dm_busy_r;

  logic                cfg_wr;
  cfg_reg_e            cfg_idx;
  logic [DILREG_W-1:0] dil_wr_clamp;
  logic [CN_W-1:0]     nch;
  logic [TN_W-1:0]     ntap;
  logic [DILREG_W-1:0] dil;
  logic [STEP_W-1:0]   warm, lim, nfr;

  assign pready  = 1'b1;
  assign cfg_idx = cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      REG_CHANNELS: prdata = 32'(ch_r);
      REG_TAPS:     prdata = 32'(tap_r);
      REG_DILATION: prdata = 32'(dil_r);
      REG_FRAME:    prdata = 32'(fr_r);
      default:      prdata = '0;
    endcase
  end

  // zero counts as one, large values stop at the build limits
  assign dil_wr_clamp = (pwdata[DILREG_W-1:0] == '0) ? DILREG_W'(1)
                      : (32'(pwdata[DILREG_W-1:0]) > MAX_DILATION) ? DILREG_W'(MAX_DILATION)
                      : pwdata[DILREG_W-1:0];
  assign nch  = (ch_r == '0) ? CN_W'(1)
              : (32'(ch_r) > MAX_CHANNELS) ? CN_W'(MAX_CHANNELS) : CN_W'(ch_r);
  assign ntap = (tap_r == '0) ? TN_W'(1)
              : (32'(tap_r) > MAX_TAPS) ? TN_W'(MAX_TAPS) : TN_W'(tap_r);
  assign dil  = (dil_r == '0) ? DILREG_W'(1)
              : (32'(dil_r) > MAX_DILATION) ? DILREG_W'(MAX_DILATION) : dil_r;
  assign nfr  = (fr_r == '0) ? STEP_W'(1) : STEP_W'(fr_r);
  // warm-up steps before the first result of a frame
  assign warm = STEP_W'(32'(ntap - TN_W'(1)) * 32'(dil));
  assign lim  = warm + nfr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r      <= CHREG_W'(1);
      tap_r     <= TAPREG_W'(1);
      dil_r     <= DILREG_W'(1);
      fr_r      <= FRREG_W'(64);
      dm_r      <= DILREG_W'(1);
      dm_busy_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_CHANNELS: ch_r <= pwdata[CHREG_W-1:0];
          REG_TAPS:     tap_r <= pwdata[TAPREG_W-1:0];
          REG_DILATION: begin
            dil_r     <= pwdata[DILREG_W-1:0];
            dm_r      <= dil_wr_clamp;
            dm_busy_r <= 1'b1;
          end
          REG_FRAME:    fr_r <= pwdata[FRREG_W-1:0];
          default:      ;
        endcase
      end else if (dm_busy_r) begin
        // one subtraction of the ring size per cycle
        if (32'(dm_r) >= HISTORY_DEPTH) begin
          dm_r <= dm_r - DILREG_W'(HISTORY_DEPTH);
        end else begin
          dm_busy_r <= 1'b0;
        end
      end
    end
  end

  // request fields
  logic              in_func;
  logic [CH_FW-1:0]  in_oc, in_ic;
  logic [TAP_FW-1:0] in_tap;
  logic [VAL_FW-1:0] in_value;

  assign in_func  = in_tuser;
  assign in_oc    = in_tdata[3:0];
  assign in_ic    = in_tdata[7:4];
  assign in_tap   = in_tdata[10:8];
  assign in_value = in_tdata[26:11];

  // sequencer <-> stores <-> MAC
  logic               w_we, h_we;
  logic [WA_W-1:0]    w_waddr, w_raddr;
  logic [HA_W-1:0]    h_waddr, h_raddr;
  logic [VAL_FW-1:0]  w_rdata, h_rdata;
  mac_ctrl_t          mac_ctl;
  logic               mac_done;
  logic [VAL_FW-1:0]  mac_res;
  logic               out_load;
  logic [CH_FW-1:0]   res_ch;
  logic [TIDX_FW-1:0] res_tidx;
  logic               res_last;

  dcq_seq #(
    .MAX_CHANNELS  (MAX_CHANNELS),
    .MAX_TAPS      (MAX_TAPS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_tvalid),
    .in_ready_o  (in_tready),
    .func_i      (in_func),
    .oc_i        (in_oc),
    .ic_i        (in_ic),
    .tap_i       (in_tap),
    .hold_i      (dm_busy_r),
    .cfg_wr_i    (cfg_wr),
    .nch_i       (nch),
    .ntap_i      (ntap),
    .dmod_i      (HP_W'(dm_r)),
    .warm_i      (warm),
    .lim_i       (lim),
    .w_we_o      (w_we),
    .w_waddr_o   (w_waddr),
    .w_raddr_o   (w_raddr),
    .h_we_o      (h_we),
    .h_waddr_o   (h_waddr),
    .h_raddr_o   (h_raddr),
    .ctl_o       (mac_ctl),
    .mac_done_i  (mac_done),
    .out_valid_i (out_tvalid),
    .out_ready_i (out_tready),
    .out_load_o  (out_load),
    .res_ch_o    (res_ch),
    .res_tidx_o  (res_tidx),
    .res_last_o  (res_last)
  );

  dcq_ram #(
    .WIDTH (VAL_FW),
    .DEPTH (WDEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (in_value),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  dcq_ram #(
    .WIDTH (VAL_FW),
    .DEPTH (HDEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (in_value),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  dcq_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (mac_ctl),
    .w_i    ($signed(w_rdata)),
    .x_i    ($signed(h_rdata)),
    .done_o (mac_done),
    .res_o  (mac_res)
  );

  // output register: one result held until the receiver takes it
  logic        out_valid_r;
  logic [35:0] out_data_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {mac_res, res_tidx, res_ch};
      out_last_r <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_data_r};
  assign out_tlast  = out_last_r;

  `ASSERT_CLK(a_no_overwrite, out_load |-> !out_valid_r || out_tready,
              "pending result overwritten")
  `ASSERT_NEVER(a_rdy_busy, in_tready && dm_busy_r,
                "request taken during dilation reduction")
  `ASSERT_CLK(a_dm_range, !dm_busy_r |-> 32'(dm_r) < HISTORY_DEPTH,
              "dilation step not reduced below ring size")

endmodule

// ----- rtl/dcq_ram.sv -----
`timescale 1ns / 1ps

module dcq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/dcq_mac.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dcq_mac import dcq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctrl_t                ctl_i,
  input  logic signed [VAL_FW-1:0] w_i,
  input  logic signed [VAL_FW-1:0] x_i,
  output logic                     done_o,
  output logic [VAL_FW-1:0]        res_o
);

  mac_ctrl_t          ctl_d1_r, ctl_d2_r;
  logic signed [31:0] prod_r;
  logic [31:0]        acc_r;
  logic               done_r;
  logic signed [16:0] shifted;

  // ctl_d1 lines up with RAM read data, ctl_d2 with the product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d1_r <= '0;
      ctl_d2_r <= '0;
      done_r   <= 1'b0;
    end else begin
      ctl_d1_r <= ctl_i;
      ctl_d2_r <= ctl_d1_r;
      if (ctl_i.valid && ctl_i.first) begin
        done_r <= 1'b0;
      end else if (ctl_d2_r.valid && ctl_d2_r.last) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= w_i * x_i;
    if (ctl_d2_r.valid) begin
      acc_r <= ctl_d2_r.first ? 32'(prod_r) : acc_r + 32'(prod_r);
    end
  end

  // floor shift by 15, then saturate to int16
  assign shifted = 17'($signed(acc_r) >>> Q15_SHIFT);

  always_comb begin
    if (!shifted[16] && shifted[15]) begin
      res_o = 16'h7fff;
    end else if (shifted[16] && !shifted[15]) begin
      res_o = 16'h8000;
    end else begin
      res_o = shifted[15:0];
    end
  end

  assign done_o = done_r;

  `ASSERT_CLK(a_done_clr, ctl_i.valid && ctl_i.first |=> !done_r,
              "result flag still set after a new sum began")
  `ASSERT_NEVER(a_first_mid, ctl_d2_r.valid && ctl_d2_r.last && ctl_i.valid && !ctl_i.first
                && !ctl_d1_r.valid, "sum closed while its successor ran headless")

endmodule

// ----- rtl/dcq_seq.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dcq_seq import dcq_pkg::*; #(
  parameter int unsigned MAX_CHANNELS  = 16,
  parameter int unsigned MAX_TAPS      = 8,
  parameter int unsigned HISTORY_DEPTH = 512,
  localparam int unsigned CI_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int unsigned CN_W = $clog2(MAX_CHANNELS + 1),
  localparam int unsigned TI_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
  localparam int unsigned TN_W = $clog2(MAX_TAPS + 1),
  localparam int unsigned HP_W = $clog2(HISTORY_DEPTH),
  localparam int unsigned WDEPTH = MAX_CHANNELS * MAX_CHANNELS * MAX_TAPS,
  localparam int unsigned HDEPTH = HISTORY_DEPTH * MAX_CHANNELS,
  localparam int unsigned WA_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1,
  localparam int unsigned HA_W = $clog2(HDEPTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  // request side
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [CH_FW-1:0]   oc_i,
  input  logic [CH_FW-1:0]   ic_i,
  input  logic [TAP_FW-1:0]  tap_i,
  // settings
  input  logic               hold_i,
  input  logic               cfg_wr_i,
  input  logic [CN_W-1:0]    nch_i,
  input  logic [TN_W-1:0]    ntap_i,
  input  logic [HP_W-1:0]    dmod_i,
  input  logic [STEP_W-1:0]  warm_i,
  input  logic [STEP_W-1:0]  lim_i,
  // stores
  output logic               w_we_o,
  output logic [WA_W-1:0]    w_waddr_o,
  output logic [WA_W-1:0]    w_raddr_o,
  output logic               h_we_o,
  output logic [HA_W-1:0]    h_waddr_o,
  output logic [HA_W-1:0]    h_raddr_o,
  // MAC
  output mac_ctrl_t          ctl_o,
  input  logic               mac_done_i,
  // result side
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  output logic               out_load_o,
  output logic [CH_FW-1:0]   res_ch_o,
  output logic [TIDX_FW-1:0] res_tidx_o,
  output logic               res_last_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MAC  = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [STEP_W-1:0]    step_r, step_inc;
  logic [HP_W-1:0]      hp_r;
  logic [CI_W-1:0]      co_r, ci_r;
  logic [TI_W-1:0]      k_r;
  logic [HP_W-1:0]      slot_r, slot_dec;
  logic [TIDX_FW-1:0]   tidx_r;
  logic                 acc_in, smp_ok, ch_last, start_mac, adv_step;
  logic                 k_end, ci_end, co_end;
  logic [TI_W-1:0]      k_top;

  assign k_top  = TI_W'(ntap_i - TN_W'(1));
  assign k_end  = (k_r == '0);
  assign ci_end = (32'(ci_r) == 32'(nch_i) - 32'd1);
  assign co_end = (32'(co_r) == 32'(nch_i) - 32'd1);

  assign in_ready_o = (state_r == S_IDLE) && !hold_i;
  assign acc_in     = in_valid_i && in_ready_o;
  assign smp_ok     = acc_in && func_i && (32'(ic_i) < 32'(nch_i));
  assign ch_last    = smp_ok && (32'(ic_i) == 32'(nch_i) - 32'd1);
  assign start_mac  = ch_last && (step_r >= warm_i);
  assign out_load_o = (state_r == S_WAIT) && mac_done_i && (!out_valid_i || out_ready_i);
  assign adv_step   = (ch_last && !start_mac) || (out_load_o && co_end);

  assign w_we_o    = acc_in && !func_i && (32'(oc_i) < MAX_CHANNELS)
                     && (32'(ic_i) < MAX_CHANNELS) && (32'(tap_i) < MAX_TAPS);
  assign w_waddr_o = WA_W'(32'(oc_i) * (MAX_CHANNELS * MAX_TAPS) + 32'(ic_i) * MAX_TAPS
                     + 32'(tap_i));
  assign h_we_o    = smp_ok;
  assign h_waddr_o = HA_W'(32'(hp_r) * MAX_CHANNELS + 32'(ic_i));

  assign w_raddr_o = WA_W'(32'(co_r) * (MAX_CHANNELS * MAX_TAPS) + 32'(ci_r) * MAX_TAPS
                     + 32'(k_r));
  assign h_raddr_o = HA_W'(32'(slot_r) * MAX_CHANNELS + 32'(ci_r));

  assign ctl_o.valid = (state_r == S_MAC);
  assign ctl_o.first = (ci_r == '0) && (k_r == k_top);
  assign ctl_o.last  = ci_end && k_end;

  // one tap further back: subtract dilation modulo the ring
  assign slot_dec = (slot_r >= dmod_i) ? slot_r - dmod_i
                    : HP_W'(32'(slot_r) + HISTORY_DEPTH - 32'(dmod_i));

  assign step_inc   = step_r + STEP_W'(1);
  assign res_ch_o   = CH_FW'(co_r);
  assign res_tidx_o = tidx_r;
  assign res_last_o = co_end;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start_mac) state_nxt = S_MAC;
      S_MAC:  if (k_end && ci_end) state_nxt = S_WAIT;
      S_WAIT: if (out_load_o) state_nxt = co_end ? S_IDLE : S_MAC;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      hp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_i) begin
        step_r <= '0;
      end else if (adv_step) begin
        step_r <= (step_inc >= lim_i) ? '0 : step_inc;
      end
      if (adv_step) begin
        hp_r <= (32'(hp_r) == HISTORY_DEPTH - 1) ? '0 : hp_r + HP_W'(1);
      end
    end
  end

  // loop counters, set up before every use
  always_ff @(posedge clk) begin
    if (start_mac) begin
      tidx_r <= TIDX_FW'(step_r - warm_i);
      co_r   <= '0;
      ci_r   <= '0;
      k_r    <= k_top;
      slot_r <= hp_r;
    end else if (state_r == S_MAC) begin
      if (k_end) begin
        k_r    <= k_top;
        slot_r <= hp_r;
        ci_r   <= ci_r + CI_W'(1);
      end else begin
        k_r    <= k_r - TI_W'(1);
        slot_r <= slot_dec;
      end
    end else if (out_load_o && !co_end) begin
      co_r   <= co_r + CI_W'(1);
      ci_r   <= '0;
      k_r    <= k_top;
      slot_r <= hp_r;
    end
  end

  `ASSERT_NEVER(a_wr_in_mac, ctl_o.valid && (w_we_o || h_we_o),
                "store written while a sum is being read")
  `ASSERT_CLK(a_k_range, state_r == S_MAC |-> 32'(k_r) < 32'(ntap_i),
              "tap counter beyond kernel length")
  `ASSERT_CLK(a_step_range, step_r < lim_i || $past(cfg_wr_i),
              "step counter past the end of the frame")

endmodule
